[sv/assert_macros.svh]
// Assertion helpers for the RTL. Empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MTEP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed: property violated");
`define MTEP_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("assertion failed: forbidden condition seen");
`else
`define MTEP_ASSERT(lbl, clk, rstn, prop)
`define MTEP_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[sv/mtep_pkg.sv]
package mtep_pkg;

  // input beat kinds
  localparam logic [1:0] KIND_RESET = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // status and meta codes
  localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
  localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
  localparam logic [7:0] STATUS_META   = 8'hFF;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] META_TIMESIG  = 8'h58;
  localparam logic [7:0] META_EOT      = 8'h2F;

  // high nibble of a status byte
  localparam logic [3:0] TYPE_NOTE_OFF  = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON   = 4'h9;
  localparam logic [3:0] TYPE_POLY      = 4'hA;
  localparam logic [3:0] TYPE_CC        = 4'hB;
  localparam logic [3:0] TYPE_PROGRAM   = 4'hC;
  localparam logic [3:0] TYPE_CHANPRESS = 4'hD;
  localparam logic [3:0] TYPE_SYSTEM    = 4'hF;

  // a variable-length quantity stops after four bytes: at most 28 value bits
  localparam int unsigned   VLQ_W         = 28;
  localparam logic [2:0]    VLQ_MAX_BYTES = 3'd4;

  typedef enum logic [1:0] {
    CLS_RESET,
    CLS_BYTE,
    CLS_END
  } item_cls_e;

  typedef struct packed {
    item_cls_e  cls;
    logic [7:0] data;
    logic       is_status;
    logic       is_meta;
    logic       is_sysex;
    logic       is_undef;
  } item_t;

  typedef enum logic [3:0] {
    PH_DELTA,
    PH_STATUS,
    PH_D1,
    PH_D2,
    PH_META_TYPE,
    PH_META_LEN,
    PH_META_DATA,
    PH_SX_LEN,
    PH_SX_DATA,
    PH_EOT,
    PH_STOP
  } phase_e;

  typedef enum logic [4:0] {
    EV_NOTE_OFF    = 5'd0,
    EV_NOTE_ON     = 5'd1,
    EV_POLY        = 5'd2,
    EV_CC          = 5'd3,
    EV_PROGRAM     = 5'd4,
    EV_CHANPRESS   = 5'd5,
    EV_BEND        = 5'd6,
    EV_TEMPO       = 5'd7,
    EV_TIMESIG     = 5'd8,
    EV_END         = 5'd9,
    EV_META_OTHER  = 5'd10,
    EV_SYSEX_START = 5'd11,
    EV_SYSEX_BYTE  = 5'd12,
    EV_DONE        = 5'd13,
    EV_NO_RUNNING  = 5'd14,
    EV_BAD_STATUS  = 5'd15,
    EV_TRUNCATED   = 5'd16
  } event_e;

  typedef struct packed {
    event_e      kind;
    logic [3:0]  ch;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [31:0] wide;
    logic        last;
  } result_t;

  // min-center-max upscaling, 7 to 16 bits
  function automatic logic [15:0] upscale7_16(logic [7:0] b);
    logic [6:0]  v;
    logic [5:0]  r;
    logic [15:0] res;
    v   = b[6:0];
    r   = v[5:0];
    res = {v, 9'b0};
    if (v > 7'd64) begin
      res = res | {7'b0, r, 3'b0} | {13'b0, r[5:3]};
    end
    return res;
  endfunction

  // min-center-max upscaling, 7 to 32 bits
  function automatic logic [31:0] upscale7_32(logic [7:0] b);
    logic [6:0]  v;
    logic [31:0] r;
    logic [31:0] res;
    v   = b[6:0];
    r   = {26'b0, v[5:0]};
    res = {v, 25'b0};
    if (v > 7'd64) begin
      res = res | (r << 19) | (r << 13) | (r << 7) | (r << 1) | (r >> 5);
    end
    return res;
  endfunction

  // min-center-max upscaling, 14 to 32 bits
  function automatic logic [31:0] upscale14_32(logic [13:0] v);
    logic [31:0] r;
    logic [31:0] res;
    r   = {19'b0, v[12:0]};
    res = {v, 18'b0};
    if (v > 14'd8192) begin
      res = res | (r << 5) | (r >> 8);
    end
    return res;
  endfunction

endpackage

[sv/mtep_front.sv]
module mtep_front (
  input  logic               valid_i,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         data_byte_i,
  output logic               stall_o,
  input  logic               full_i,
  output logic               wr_o,
  output mtep_pkg::item_t    item_o
);

  logic accept;

  assign stall_o = full_i;
  assign accept  = valid_i && !full_i;

  always_comb begin
    item_o           = '0;
    item_o.data      = data_byte_i;
    item_o.is_status = data_byte_i[7];
    item_o.is_meta   = (data_byte_i == mtep_pkg::STATUS_META);
    item_o.is_sysex  = (data_byte_i == mtep_pkg::STATUS_SYSEX) ||
                       (data_byte_i == mtep_pkg::STATUS_ESCAPE);
    item_o.is_undef  = (data_byte_i[7:4] == mtep_pkg::TYPE_SYSTEM) &&
                       !item_o.is_meta && !item_o.is_sysex;
    wr_o             = 1'b0;
    unique case (kind_i)
      mtep_pkg::KIND_RESET: begin
        item_o.cls = mtep_pkg::CLS_RESET;
        wr_o       = accept;
      end
      mtep_pkg::KIND_BYTE: begin
        item_o.cls = mtep_pkg::CLS_BYTE;
        wr_o       = accept;
      end
      mtep_pkg::KIND_END: begin
        item_o.cls = mtep_pkg::CLS_END;
        wr_o       = accept;
      end
      default: begin
        // unused kind: take the beat and drop it
        item_o.cls = mtep_pkg::CLS_BYTE;
        wr_o       = 1'b0;
      end
    endcase
  end

endmodule

[sv/mtep_fifo.sv]
module mtep_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  mtep_pkg::item_t item_i,
  output logic            full_o,
  input  logic            rd_i,
  output logic            valid_o,
  output mtep_pkg::item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mtep_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_i && !rd_i) begin
      count_d = count_q + CntW'(1);
    end else if (rd_i && !wr_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[sv/mtep_back.sv]
`include "assert_macros.svh"

module mtep_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  mtep_pkg::item_t   item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [4:0]        event_kind_o,
  output logic [31:0]       tick_o,
  output logic [3:0]        channel_o,
  output logic [7:0]        first_data_o,
  output logic [7:0]        second_data_o,
  output logic [31:0]       wide_value_o,
  output logic              last_payload_o
);

  localparam int unsigned W = mtep_pkg::VLQ_W;

  mtep_pkg::phase_e  phase_q, phase_d;
  logic [7:0]        running_q, running_d;
  logic [31:0]       tick_q, tick_d;
  logic [W-1:0]      vlq_acc_q, vlq_acc_d;
  logic [2:0]        vlq_cnt_q, vlq_cnt_d;
  logic [7:0]        active_q, active_d;
  logic [7:0]        held_q, held_d;
  logic [7:0]        meta_code_q, meta_code_d;
  logic [W-1:0]      bytes_left_q, bytes_left_d;
  logic [23:0]       tempo_q, tempo_d;
  logic [1:0]        meta_idx_q, meta_idx_d;

  logic              out_valid_q;
  mtep_pkg::result_t out_q;
  logic [31:0]       out_tick_q;

  mtep_pkg::result_t res;
  logic              res_vld;
  logic              first_data;
  logic              fin_meta;
  logic [7:0]        b;
  logic [W-1:0]      vlq_acc_nx;
  logic [2:0]        vlq_cnt_nx;
  logic              vlq_done;
  logic [W-1:0]      bytes_dec;

  assign b          = item_i.data;
  assign pop_o      = item_valid_i && (!out_valid_q || !out_stall_i);
  assign vlq_acc_nx = {vlq_acc_q[W-8:0], b[6:0]};
  assign vlq_cnt_nx = vlq_cnt_q + 3'd1;
  assign vlq_done   = !b[7] || (vlq_cnt_nx >= mtep_pkg::VLQ_MAX_BYTES);
  assign bytes_dec  = bytes_left_q - W'(1);

  always_comb begin
    phase_d      = phase_q;
    running_d    = running_q;
    tick_d       = tick_q;
    vlq_acc_d    = vlq_acc_q;
    vlq_cnt_d    = vlq_cnt_q;
    active_d     = active_q;
    held_d       = held_q;
    meta_code_d  = meta_code_q;
    bytes_left_d = bytes_left_q;
    tempo_d      = tempo_q;
    meta_idx_d   = meta_idx_q;
    res          = '0;
    res_vld      = 1'b0;
    first_data   = 1'b0;
    fin_meta     = 1'b0;

    if (pop_o) begin
      unique case (item_i.cls)
        mtep_pkg::CLS_RESET: begin
          phase_d      = mtep_pkg::PH_DELTA;
          running_d    = '0;
          tick_d       = '0;
          vlq_acc_d    = '0;
          vlq_cnt_d    = '0;
          active_d     = '0;
          held_d       = '0;
          meta_code_d  = '0;
          bytes_left_d = '0;
          tempo_d      = '0;
          meta_idx_d   = '0;
        end
        mtep_pkg::CLS_END: begin
          if (phase_q != mtep_pkg::PH_STOP) begin
            phase_d = mtep_pkg::PH_STOP;
            res_vld = 1'b1;
            if (phase_q == mtep_pkg::PH_EOT ||
                (phase_q == mtep_pkg::PH_DELTA && vlq_cnt_q == '0)) begin
              res.kind = mtep_pkg::EV_DONE;
            end else begin
              res.kind = mtep_pkg::EV_TRUNCATED;
            end
          end
        end
        mtep_pkg::CLS_BYTE: begin
          unique case (phase_q)
            mtep_pkg::PH_DELTA: begin
              if (vlq_done) begin
                tick_d    = tick_q + {{(32-W){1'b0}}, vlq_acc_nx};
                vlq_acc_d = '0;
                vlq_cnt_d = '0;
                phase_d   = mtep_pkg::PH_STATUS;
              end else begin
                vlq_acc_d = vlq_acc_nx;
                vlq_cnt_d = vlq_cnt_nx;
              end
            end
            mtep_pkg::PH_STATUS: begin
              if (!item_i.is_status) begin
                if (running_q == '0) begin
                  phase_d  = mtep_pkg::PH_STOP;
                  res_vld  = 1'b1;
                  res.kind = mtep_pkg::EV_NO_RUNNING;
                end else begin
                  active_d = running_q;
                  if (!running_q[7] || running_q[7:4] == mtep_pkg::TYPE_SYSTEM) begin
                    phase_d  = mtep_pkg::PH_STOP;
                    res_vld  = 1'b1;
                    res.kind = mtep_pkg::EV_BAD_STATUS;
                    res.ch   = running_q[3:0];
                  end else begin
                    first_data = 1'b1;
                  end
                end
              end else begin
                if (!item_i.is_meta && !item_i.is_sysex) begin
                  running_d = b;
                end
                active_d = b;
                if (item_i.is_meta) begin
                  phase_d = mtep_pkg::PH_META_TYPE;
                end else if (item_i.is_sysex) begin
                  vlq_acc_d = '0;
                  vlq_cnt_d = '0;
                  phase_d   = mtep_pkg::PH_SX_LEN;
                end else if (item_i.is_undef) begin
                  phase_d  = mtep_pkg::PH_STOP;
                  res_vld  = 1'b1;
                  res.kind = mtep_pkg::EV_BAD_STATUS;
                  res.ch   = b[3:0];
                end else begin
                  phase_d = mtep_pkg::PH_D1;
                end
              end
            end
            mtep_pkg::PH_D1: begin
              first_data = 1'b1;
            end
            mtep_pkg::PH_D2: begin
              phase_d = mtep_pkg::PH_DELTA;
              res_vld = 1'b1;
              res.ch  = active_q[3:0];
              res.d1  = held_q;
              res.d2  = b;
              case (active_q[7:4])
                mtep_pkg::TYPE_NOTE_OFF: begin
                  res.kind = mtep_pkg::EV_NOTE_OFF;
                  res.wide = {16'b0, mtep_pkg::upscale7_16(b)};
                end
                mtep_pkg::TYPE_NOTE_ON: begin
                  // velocity zero on the raw byte means note off
                  res.kind = (b == '0) ? mtep_pkg::EV_NOTE_OFF : mtep_pkg::EV_NOTE_ON;
                  res.wide = {16'b0, mtep_pkg::upscale7_16(b)};
                end
                mtep_pkg::TYPE_POLY: begin
                  res.kind = mtep_pkg::EV_POLY;
                  res.wide = mtep_pkg::upscale7_32(b);
                end
                mtep_pkg::TYPE_CC: begin
                  res.kind = mtep_pkg::EV_CC;
                  res.wide = mtep_pkg::upscale7_32(b);
                end
                default: begin
                  res.kind = mtep_pkg::EV_BEND;
                  res.wide = mtep_pkg::upscale14_32({b[6:0], held_q[6:0]});
                end
              endcase
            end
            mtep_pkg::PH_META_TYPE: begin
              meta_code_d = b;
              meta_idx_d  = '0;
              tempo_d     = '0;
              vlq_acc_d   = '0;
              vlq_cnt_d   = '0;
              phase_d     = mtep_pkg::PH_META_LEN;
            end
            mtep_pkg::PH_META_LEN: begin
              if (vlq_done) begin
                bytes_left_d = vlq_acc_nx;
                vlq_acc_d    = '0;
                vlq_cnt_d    = '0;
                if (vlq_acc_nx == '0) begin
                  fin_meta = 1'b1;
                end else begin
                  phase_d = mtep_pkg::PH_META_DATA;
                end
              end else begin
                vlq_acc_d = vlq_acc_nx;
                vlq_cnt_d = vlq_cnt_nx;
              end
            end
            mtep_pkg::PH_META_DATA: begin
              if (meta_code_q == mtep_pkg::META_TEMPO && meta_idx_q != 2'd3) begin
                tempo_d    = {tempo_q[15:0], b};
                meta_idx_d = meta_idx_q + 2'd1;
              end
              bytes_left_d = bytes_dec;
              fin_meta     = (bytes_dec == '0);
            end
            mtep_pkg::PH_SX_LEN: begin
              if (vlq_done) begin
                bytes_left_d = vlq_acc_nx;
                vlq_acc_d    = '0;
                vlq_cnt_d    = '0;
                phase_d      = (vlq_acc_nx == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SX_DATA;
                res_vld      = 1'b1;
                res.kind     = mtep_pkg::EV_SYSEX_START;
                res.ch       = active_q[3:0];
                res.wide     = {{(32-W){1'b0}}, vlq_acc_nx};
              end else begin
                vlq_acc_d = vlq_acc_nx;
                vlq_cnt_d = vlq_cnt_nx;
              end
            end
            mtep_pkg::PH_SX_DATA: begin
              bytes_left_d = bytes_dec;
              if (bytes_dec == '0) begin
                phase_d = mtep_pkg::PH_DELTA;
              end
              res_vld  = 1'b1;
              res.kind = mtep_pkg::EV_SYSEX_BYTE;
              res.ch   = active_q[3:0];
              res.wide = {24'b0, b};
              res.last = (bytes_dec == '0);
            end
            default: ;  // end of track or halted: drop the byte
          endcase
        end
        default: ;
      endcase

      // first data byte of a channel message, status already in active_d
      if (first_data) begin
        held_d = b;
        case (active_d[7:4])
          mtep_pkg::TYPE_PROGRAM: begin
            phase_d  = mtep_pkg::PH_DELTA;
            res_vld  = 1'b1;
            res.kind = mtep_pkg::EV_PROGRAM;
            res.ch   = active_d[3:0];
            res.d1   = b;
          end
          mtep_pkg::TYPE_CHANPRESS: begin
            phase_d  = mtep_pkg::PH_DELTA;
            res_vld  = 1'b1;
            res.kind = mtep_pkg::EV_CHANPRESS;
            res.ch   = active_d[3:0];
            res.d1   = b;
            res.wide = mtep_pkg::upscale7_32(b);
          end
          default: begin
            phase_d = mtep_pkg::PH_D2;
          end
        endcase
      end

      if (fin_meta) begin
        phase_d = mtep_pkg::PH_DELTA;
        res.ch  = 4'hF;
        case (meta_code_q)
          mtep_pkg::META_TEMPO: begin
            // short tempo gives nothing
            res_vld  = (meta_idx_d == 2'd3);
            res.kind = mtep_pkg::EV_TEMPO;
            res.wide = {8'b0, tempo_d};
          end
          mtep_pkg::META_TIMESIG: begin
            res_vld  = 1'b1;
            res.kind = mtep_pkg::EV_TIMESIG;
          end
          mtep_pkg::META_EOT: begin
            phase_d  = mtep_pkg::PH_EOT;
            res_vld  = 1'b1;
            res.kind = mtep_pkg::EV_END;
          end
          default: begin
            res_vld  = 1'b1;
            res.kind = mtep_pkg::EV_META_OTHER;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= mtep_pkg::PH_DELTA;
      running_q    <= '0;
      tick_q       <= '0;
      vlq_acc_q    <= '0;
      vlq_cnt_q    <= '0;
      active_q     <= '0;
      held_q       <= '0;
      meta_code_q  <= '0;
      bytes_left_q <= '0;
      tempo_q      <= '0;
      meta_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      running_q    <= running_d;
      tick_q       <= tick_d;
      vlq_acc_q    <= vlq_acc_d;
      vlq_cnt_q    <= vlq_cnt_d;
      active_q     <= active_d;
      held_q       <= held_d;
      meta_code_q  <= meta_code_d;
      bytes_left_q <= bytes_left_d;
      tempo_q      <= tempo_d;
      meta_idx_q   <= meta_idx_d;
      if (pop_o) begin
        out_valid_q <= res_vld;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the beat while stalled, load a new one only on a pop
  always_ff @(posedge clk_i) begin
    if (pop_o && res_vld) begin
      out_q      <= res;
      out_tick_q <= tick_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = out_q.kind;
  assign tick_o         = out_tick_q;
  assign channel_o      = out_q.ch;
  assign first_data_o   = out_q.d1;
  assign second_data_o  = out_q.d2;
  assign wide_value_o   = out_q.wide;
  assign last_payload_o = out_q.last;

  `MTEP_ASSERT(a_stop_silent, clk_i, rst_ni, pop_o && phase_q == mtep_pkg::PH_STOP && item_i.cls != mtep_pkg::CLS_RESET |=> !out_valid_q)
  `MTEP_ASSERT(a_reset_item, clk_i, rst_ni, pop_o && item_i.cls == mtep_pkg::CLS_RESET |=> phase_q == mtep_pkg::PH_DELTA && tick_q == '0 && running_q == '0)
  `MTEP_ASSERT_NEVER(a_vlq_len, clk_i, rst_ni, vlq_cnt_q > mtep_pkg::VLQ_MAX_BYTES)
  `MTEP_ASSERT_NEVER(a_meta_left, clk_i, rst_ni, phase_q == mtep_pkg::PH_META_DATA && bytes_left_q == '0)

endmodule

[sv/midi_track_event_parser.sv]
// Track chunk parser: one byte of a track body per input beat, one event per result.
// Input channel: in_valid_i / in_stall_o, payload kind_i (0 restart track and clear
// state, 1 track byte in data_byte_i, 2 end of track data; 3 is taken and dropped).
// Output channel: out_valid_o / out_stall_i, payload event_kind_o, tick_o, channel_o,
// first_data_o, second_data_o, wide_value_o, last_payload_o.
// A front stage classifies each beat and writes it to a QueueDepth-entry queue; the
// back stage pops one beat a cycle while its output register is free, steps the parse
// state machine and loads the output register. Each beat passes the queue and then
// the output register; both sides sustain one beat per cycle while the output is not
// stalled. Bytes that close no event (delta time, lengths, meta data) give no result.
// The back stage pops only while the output register is empty or being taken, so a
// stall on the output fills the queue, then raises in_stall_o; no beat is lost.
// Reset clears the queue, the output register and the parse state (waiting for a
// delta time, tick zero, no running status). After an error or done, bytes are
// dropped until a kind 0 beat restarts the track.
module midi_track_event_parser #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  event_kind_o,
  output logic [31:0] tick_o,
  output logic [3:0]  channel_o,
  output logic [7:0]  first_data_o,
  output logic [7:0]  second_data_o,
  output logic [31:0] wide_value_o,
  output logic        last_payload_o
);

  mtep_pkg::item_t wr_item;
  mtep_pkg::item_t rd_item;
  logic            wr;
  logic            full;
  logic            rd;
  logic            q_valid;

  mtep_front u_front (
    .valid_i     (in_valid_i),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .stall_o     (in_stall_o),
    .full_i      (full),
    .wr_o        (wr),
    .item_o      (wr_item)
  );

  mtep_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .item_i  (wr_item),
    .full_o  (full),
    .rd_i    (rd),
    .valid_o (q_valid),
    .item_o  (rd_item)
  );

  mtep_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (q_valid),
    .item_i         (rd_item),
    .pop_o          (rd),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .tick_o         (tick_o),
    .channel_o      (channel_o),
    .first_data_o   (first_data_o),
    .second_data_o  (second_data_o),
    .wide_value_o   (wide_value_o),
    .last_payload_o (last_payload_o)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct {
    mtep_pkg::event_e kind;
    logic [31:0]      tick;
    logic [3:0]       ch;
    logic [7:0]       d1;
    logic [7:0]       d2;
    logic [31:0]      wide;
    logic             is_last;
  } track_event_t;

  class event_scoreboard;
    mtep_pkg::phase_e phase;
    logic [7:0]   running_status;
    logic [7:0]   active_status;
    logic [7:0]   held_byte;
    logic [7:0]   meta_type;
    logic [31:0]  tick;
    logic [31:0]  vlq_value;
    logic [31:0]  remaining;
    logic [23:0]  tempo_us;
    int unsigned  vlq_count;
    int unsigned  tempo_count;
    int unsigned  live_beats;
    int unsigned  mismatches;
    int unsigned  events_seen;
    track_event_t expected_events[$];

    function new();
      restart();
      live_beats  = 0;
      mismatches  = 0;
      events_seen = 0;
    endfunction

    function void restart();
      phase          = mtep_pkg::PH_DELTA;
      running_status = 8'h00;
      active_status  = 8'h00;
      held_byte      = 8'h00;
      meta_type      = 8'h00;
      tick           = 32'h0;
      vlq_value      = 32'h0;
      remaining      = 32'h0;
      tempo_us       = 24'h0;
      vlq_count      = 0;
      tempo_count    = 0;
    endfunction

    function void clear_quantity();
      vlq_value = 32'h0;
      vlq_count = 0;
    endfunction

    // true once the quantity is complete; the fourth byte always closes it
    function bit vlq_take(logic [7:0] b);
      vlq_value = {vlq_value[24:0], b[6:0]};
      vlq_count++;
      return !b[7] || vlq_count >= 4;
    endfunction

    function logic [31:0] scale_up(logic [31:0] raw, int src_bits, int dst_bits);
      int          gap;
      int          half;
      logic [63:0] val;
      logic [63:0] res;
      logic [63:0] fill;
      gap  = dst_bits - src_bits;
      half = src_bits - 1;
      val  = {32'h0, raw} & ((64'd1 << src_bits) - 64'd1);
      res  = val << gap;
      if (val <= (64'd1 << half)) return res[31:0];
      fill = val & ((64'd1 << half) - 64'd1);
      if (gap > half) fill = fill << (gap - half);
      else fill = fill >> (half - gap);
      while (fill != 0) begin
        res  = res | fill;
        fill = fill >> half;
      end
      return res[31:0];
    endfunction

    function void push_event(mtep_pkg::event_e k, logic [3:0] ch, logic [7:0] d1,
                             logic [7:0] d2, logic [31:0] wide, logic is_last);
      track_event_t e;
      e.kind    = k;
      e.tick    = tick;
      e.ch      = ch;
      e.d1      = d1;
      e.d2      = d2;
      e.wide    = wide;
      e.is_last = is_last;
      expected_events.insert(expected_events.size(), e);
    endfunction

    function void halt(mtep_pkg::event_e k, logic [3:0] ch);
      phase = mtep_pkg::PH_STOP;
      push_event(k, ch, 8'h00, 8'h00, 32'h0, 1'b0);
    endfunction

    function void close_meta();
      phase = mtep_pkg::PH_DELTA;
      case (meta_type)
        mtep_pkg::META_TEMPO: begin
          if (tempo_count >= 3)
            push_event(mtep_pkg::EV_TEMPO, 4'hF, 8'h00, 8'h00, {8'h00, tempo_us}, 1'b0);
        end
        mtep_pkg::META_TIMESIG:
          push_event(mtep_pkg::EV_TIMESIG, 4'hF, 8'h00, 8'h00, 32'h0, 1'b0);
        mtep_pkg::META_EOT: begin
          phase = mtep_pkg::PH_EOT;
          push_event(mtep_pkg::EV_END, 4'hF, 8'h00, 8'h00, 32'h0, 1'b0);
        end
        default: push_event(mtep_pkg::EV_META_OTHER, 4'hF, 8'h00, 8'h00, 32'h0, 1'b0);
      endcase
    endfunction

    function void channel_byte(logic [7:0] b, bit first_byte);
      logic [3:0]  nib;
      logic [3:0]  ch;
      logic [13:0] bend_val;
      nib = active_status[7:4];
      ch  = active_status[3:0];
      if (first_byte) begin
        held_byte = b;
        if (nib == mtep_pkg::TYPE_PROGRAM) begin
          phase = mtep_pkg::PH_DELTA;
          push_event(mtep_pkg::EV_PROGRAM, ch, b, 8'h00, 32'h0, 1'b0);
        end else if (nib == mtep_pkg::TYPE_CHANPRESS) begin
          phase = mtep_pkg::PH_DELTA;
          push_event(mtep_pkg::EV_CHANPRESS, ch, b, 8'h00, scale_up({24'h0, b}, 7, 32),
                     1'b0);
        end else begin
          phase = mtep_pkg::PH_D2;
        end
        return;
      end
      phase = mtep_pkg::PH_DELTA;
      case (nib)
        mtep_pkg::TYPE_NOTE_OFF:
          push_event(mtep_pkg::EV_NOTE_OFF, ch, held_byte, b, scale_up({24'h0, b}, 7, 16),
                     1'b0);
        // velocity zero turns note on into note off; the raw byte decides
        mtep_pkg::TYPE_NOTE_ON:
          push_event((b == 8'h00) ? mtep_pkg::EV_NOTE_OFF : mtep_pkg::EV_NOTE_ON, ch,
                     held_byte, b, scale_up({24'h0, b}, 7, 16), 1'b0);
        mtep_pkg::TYPE_POLY:
          push_event(mtep_pkg::EV_POLY, ch, held_byte, b, scale_up({24'h0, b}, 7, 32),
                     1'b0);
        mtep_pkg::TYPE_CC:
          push_event(mtep_pkg::EV_CC, ch, held_byte, b, scale_up({24'h0, b}, 7, 32), 1'b0);
        default: begin
          bend_val = {b[6:0], held_byte[6:0]};
          push_event(mtep_pkg::EV_BEND, ch, held_byte, b,
                     scale_up({18'h0, bend_val}, 14, 32), 1'b0);
        end
      endcase
    endfunction

    function void status_byte(logic [7:0] b);
      if (!b[7]) begin
        if (running_status == 8'h00) begin
          halt(mtep_pkg::EV_NO_RUNNING, 4'h0);
          return;
        end
        active_status = running_status;
        if (active_status[7:4] < mtep_pkg::TYPE_NOTE_OFF ||
            active_status[7:4] == mtep_pkg::TYPE_SYSTEM) begin
          halt(mtep_pkg::EV_BAD_STATUS, active_status[3:0]);
          return;
        end
        channel_byte(b, 1'b1);
        return;
      end
      if (b != mtep_pkg::STATUS_SYSEX && b != mtep_pkg::STATUS_ESCAPE &&
          b != mtep_pkg::STATUS_META) running_status = b;
      active_status = b;
      if (b == mtep_pkg::STATUS_META) begin
        phase = mtep_pkg::PH_META_TYPE;
      end else if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_ESCAPE) begin
        clear_quantity();
        phase = mtep_pkg::PH_SX_LEN;
      end else if (b[7:4] == mtep_pkg::TYPE_SYSTEM) begin
        halt(mtep_pkg::EV_BAD_STATUS, b[3:0]);
      end else begin
        phase = mtep_pkg::PH_D1;
      end
    endfunction

    function void note_beat(logic [1:0] k, logic [7:0] b);
      if (k == mtep_pkg::KIND_RESET) begin
        restart();
        live_beats++;
        return;
      end
      if (k == KIND_SPARE || phase == mtep_pkg::PH_STOP) return;
      if (!(phase == mtep_pkg::PH_EOT && k == mtep_pkg::KIND_BYTE)) live_beats++;
      if (k == mtep_pkg::KIND_END) begin
        if (phase == mtep_pkg::PH_EOT || (phase == mtep_pkg::PH_DELTA && vlq_count == 0)) begin
          phase = mtep_pkg::PH_STOP;
          push_event(mtep_pkg::EV_DONE, 4'h0, 8'h00, 8'h00, 32'h0, 1'b0);
        end else begin
          halt(mtep_pkg::EV_TRUNCATED, 4'h0);
        end
        return;
      end
      case (phase)
        mtep_pkg::PH_DELTA: begin
          if (vlq_take(b)) begin
            tick = tick + vlq_value;
            clear_quantity();
            phase = mtep_pkg::PH_STATUS;
          end
        end
        mtep_pkg::PH_STATUS: status_byte(b);
        mtep_pkg::PH_D1:     channel_byte(b, 1'b1);
        mtep_pkg::PH_D2:     channel_byte(b, 1'b0);
        mtep_pkg::PH_META_TYPE: begin
          meta_type   = b;
          tempo_count = 0;
          tempo_us    = 24'h0;
          clear_quantity();
          phase       = mtep_pkg::PH_META_LEN;
        end
        mtep_pkg::PH_META_LEN: begin
          if (vlq_take(b)) begin
            remaining = vlq_value;
            clear_quantity();
            if (remaining == 0) close_meta();
            else phase = mtep_pkg::PH_META_DATA;
          end
        end
        mtep_pkg::PH_META_DATA: begin
          if (meta_type == mtep_pkg::META_TEMPO && tempo_count < 3) begin
            tempo_us = {tempo_us[15:0], b};
            tempo_count++;
          end
          remaining = remaining - 1;
          if (remaining == 0) close_meta();
        end
        mtep_pkg::PH_SX_LEN: begin
          if (vlq_take(b)) begin
            remaining = vlq_value;
            clear_quantity();
            phase = (remaining == 0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SX_DATA;
            push_event(mtep_pkg::EV_SYSEX_START, active_status[3:0], 8'h00, 8'h00,
                       remaining, 1'b0);
          end
        end
        mtep_pkg::PH_SX_DATA: begin
          remaining = remaining - 1;
          if (remaining == 0) phase = mtep_pkg::PH_DELTA;
          push_event(mtep_pkg::EV_SYSEX_BYTE, active_status[3:0], 8'h00, 8'h00, {24'h0, b},
                     remaining == 0);
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      if (mismatches < 60) $display("mismatch at event %0d: %s", events_seen, what);
      mismatches++;
    endtask

    task check_event(logic [4:0] k, logic [31:0] t, logic [3:0] ch, logic [7:0] d1,
                     logic [7:0] d2, logic [31:0] wide, logic is_last);
      track_event_t e;
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected event kind %0d tick %h", k, t));
        events_seen++;
        return;
      end
      e = expected_events.pop_front();
      if (k !== e.kind) report($sformatf("kind got %0d want %0d", k, e.kind));
      if (t !== e.tick) report($sformatf("tick got %h want %h", t, e.tick));
      if (ch !== e.ch) report($sformatf("channel got %h want %h", ch, e.ch));
      if (d1 !== e.d1) report($sformatf("first data got %h want %h", d1, e.d1));
      if (d2 !== e.d2) report($sformatf("second data got %h want %h", d2, e.d2));
      if (wide !== e.wide) report($sformatf("wide value got %h want %h", wide, e.wide));
      if (is_last !== e.is_last) report($sformatf("last got %b want %b", is_last, e.is_last));
      events_seen++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  kind_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [4:0]  event_kind_o;
  logic [31:0] tick_o;
  logic [3:0]  channel_o;
  logic [7:0]  first_data_o;
  logic [7:0]  second_data_o;
  logic [31:0] wide_value_o;
  logic        last_payload_o;

  event_scoreboard board;
  int          idle_pct;
  int          stall_pct;
  int          hold_cycles;
  logic [7:0]  gen_running;

  midi_track_event_parser uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .tick_o         (tick_o),
    .channel_o      (channel_o),
    .first_data_o   (first_data_o),
    .second_data_o  (second_data_o),
    .wide_value_o   (wide_value_o),
    .last_payload_o (last_payload_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when one is requested
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      board.check_event(event_kind_o, tick_o, channel_o, first_data_o, second_data_o,
                        wide_value_o, last_payload_o);
  end

  task automatic send_beat(input logic [1:0] k, input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    board.note_beat(k, b);
  endtask

  task automatic put(input logic [7:0] b);
    send_beat(mtep_pkg::KIND_BYTE, b);
  endtask

  task automatic send_vlq(input logic [27:0] v);
    int n;
    n = 1;
    while (n < 4 && (v >> (7 * n)) != 0) n++;
    for (int i = n - 1; i >= 0; i--) put({i != 0, v[7 * i +: 7]});
  endtask

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'($urandom_range(64, 65));
      3:       return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic send_delta(input bit big);
    if ($urandom_range(0, 39) == 0) begin
      // four continuation bytes: the quantity closes anyway
      repeat (4) put(8'($urandom_range(128, 255)));
    end else if (big) begin
      send_vlq(28'($urandom_range(32'h0FFF_FFFF, 32'h0800_0000)));
    end else begin
      case ($urandom_range(0, 9))
        6:       send_vlq(28'h0);
        7:       send_vlq(28'($urandom_range(0, 16383)));
        8:       send_vlq(28'($urandom_range(0, 2097151)));
        9:       send_vlq(28'($urandom_range(0, 32'h0FFF_FFFF)));
        default: send_vlq(28'($urandom_range(0, 127)));
      endcase
    end
  endtask

  task automatic send_channel_msg();
    logic [7:0] status;
    if (gen_running != 8'h00 && $urandom_range(0, 2) == 0) begin
      status = gen_running;
    end else begin
      status = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
      put(status);
      gen_running = status;
    end
    put(pick_data());
    if (status[7:4] != mtep_pkg::TYPE_PROGRAM && status[7:4] != mtep_pkg::TYPE_CHANPRESS)
      put(pick_data());
  endtask

  task automatic send_meta();
    logic [7:0] mtype;
    int         len;
    case ($urandom_range(0, 3))
      0, 1:    mtype = mtep_pkg::META_TEMPO;
      2:       mtype = mtep_pkg::META_TIMESIG;
      default: mtype = 8'($urandom);
    endcase
    // keep end of track for the close of a track
    if (mtype == mtep_pkg::META_EOT) mtype = mtep_pkg::META_TEMPO;
    put(mtep_pkg::STATUS_META);
    put(mtype);
    len = (mtype == mtep_pkg::META_TEMPO) ? $urandom_range(0, 5) : $urandom_range(0, 6);
    if ($urandom_range(0, 29) == 0) len = $urandom_range(128, 160);
    send_vlq(28'(len));
    repeat (len) put(8'($urandom));
  endtask

  task automatic send_sysex();
    int len;
    put($urandom_range(0, 1) ? mtep_pkg::STATUS_SYSEX : mtep_pkg::STATUS_ESCAPE);
    len = $urandom_range(0, 8);
    if ($urandom_range(0, 29) == 0) len = $urandom_range(128, 140);
    send_vlq(28'(len));
    repeat (len) put(8'($urandom));
  endtask

  task automatic send_noise();
    logic [1:0] k;
    repeat ($urandom_range(1, 16)) begin
      case ($urandom_range(0, 9))
        0:       k = KIND_SPARE;
        1:       k = mtep_pkg::KIND_END;
        default: k = mtep_pkg::KIND_BYTE;
      endcase
      send_beat(k, 8'($urandom));
    end
  endtask

  task automatic send_track();
    bit big;
    int n_events;
    send_beat(mtep_pkg::KIND_RESET, 8'($urandom));
    gen_running = 8'h00;
    // data byte before any status
    if ($urandom_range(0, 11) == 0) begin
      send_delta(1'b0);
      put(8'($urandom_range(0, 127)));
      send_noise();
      return;
    end
    big      = ($urandom_range(0, 5) == 0);
    n_events = big ? $urandom_range(18, 30) : $urandom_range(1, 24);
    repeat (n_events) begin
      send_delta(big);
      case ($urandom_range(0, 9))
        6, 7:    send_meta();
        8:       send_sysex();
        default: send_channel_msg();
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        send_delta(big);
        put(mtep_pkg::STATUS_META);
        put(mtep_pkg::META_EOT);
        put(8'h00);
        repeat ($urandom_range(0, 3))
          send_beat($urandom_range(0, 1) ? mtep_pkg::KIND_BYTE : KIND_SPARE, 8'($urandom));
        send_beat(mtep_pkg::KIND_END, 8'($urandom));
      end
      5: send_beat(mtep_pkg::KIND_END, 8'($urandom));
      6: begin
        // stop mid-delta or mid-event
        if ($urandom_range(0, 1)) begin
          put(8'($urandom_range(128, 255)));
        end else begin
          send_delta(big);
          put(8'($urandom_range(128, 255)));
        end
        send_beat(mtep_pkg::KIND_END, 8'($urandom));
      end
      7: begin
        send_delta(big);
        put(8'($urandom_range(8'hF1, 8'hFE)));
        send_noise();
      end
      8: send_noise();
      default: ;
    endcase
  endtask

  initial begin
    int target;
    board       = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    kind_i      <= mtep_pkg::KIND_RESET;
    data_byte_i <= 8'h00;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 0;
    gen_running = 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(mtep_pkg::KIND_RESET, 8'hFF);
    repeat (4) put(8'hFF);
    put(8'h90); put(8'h7F); put(8'hFF);
    // running status, velocity zero
    put(8'h00); put(8'h00); put(8'h00);
    put(8'h00); put(8'hEF); put(8'h7F); put(8'h7F);
    // tempo too short to report
    put(8'h00); put(mtep_pkg::STATUS_META); put(mtep_pkg::META_TEMPO);
    put(8'h02); put(8'h07); put(8'hA1);
    put(8'h00); put(mtep_pkg::STATUS_META); put(mtep_pkg::META_TEMPO); put(8'h04);
    put(8'hFF); put(8'hFF); put(8'hFF); put(8'h12);
    put(8'h00); put(mtep_pkg::STATUS_SYSEX); put(8'h02); put(8'h00); put(8'hFF);
    put(8'h00); put(mtep_pkg::STATUS_META); put(mtep_pkg::META_EOT); put(8'h00);
    put(8'h5A);
    send_beat(KIND_SPARE, 8'h00);
    send_beat(mtep_pkg::KIND_END, 8'h00);
    send_beat(mtep_pkg::KIND_END, 8'h00);
    send_beat(mtep_pkg::KIND_RESET, 8'h00);
    put(8'h00); put(8'h40); put(8'h90);
    send_beat(mtep_pkg::KIND_RESET, 8'h00);
    put(8'h00); put(8'hF4);
    send_beat(mtep_pkg::KIND_RESET, 8'h00);
    put(8'h00); put(8'hC3); put(8'h80);
    put(8'h00); put(8'hD0);
    send_beat(mtep_pkg::KIND_END, 8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 52; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      // long receiver hold-off while beats keep coming
      hold_cycles = 80;
      target = board.live_beats + 350;
      while (board.live_beats < target) send_track();
    end

    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (board.expected_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_events.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/mtep_pkg.sv
sv/mtep_front.sv
sv/mtep_fifo.sv
sv/mtep_back.sv
sv/midi_track_event_parser.sv
tb/testbench.sv
